/* rtl/core/assert_macros.svh */
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk, off while rst_n is low
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// next-cycle implication
`define AQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

/* rtl/core/affq_pkg.sv */
// ---------------------------------------------------------------------------
// affq_pkg
// types and constants of the int8 affine quantizer
// ---------------------------------------------------------------------------
package affq_pkg;

  // operation carried in tuser of each request
  typedef enum logic [1:0] {
    OP_QUANT   = 2'd0,
    OP_DEQUANT = 2'd1,
    OP_FAKE    = 2'd2
  } op_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_MODE_SYM  = 2'd0,
    CFG_SCALE     = 2'd1,
    CFG_INV_SCALE = 2'd2,
    CFG_ZERO_PT   = 2'd3
  } cfg_idx_t;

  localparam int unsigned StageCount = 6;

  localparam logic [31:0] ScaleReset    = 32'h0100_0000;
  localparam logic [31:0] InvScaleReset = 32'h0001_0000;

  // clamp limits, 35-bit signed for the rounded quantizer sum
  localparam logic signed [34:0] AsymLo = 35'sd0;
  localparam logic signed [34:0] AsymHi = 35'sd255;
  localparam logic signed [34:0] SymLo  = -35'sd127;
  localparam logic signed [34:0] SymHi  = 35'sd127;

  // code limits as 9-bit output patterns
  localparam logic [8:0] CodeZero   = 9'h000;
  localparam logic [8:0] CodeU8Max  = 9'h0ff;
  localparam logic [8:0] CodeS8Max  = 9'h07f;
  localparam logic [8:0] CodeS8Min  = 9'h181;

  localparam logic [31:0] RealPosMax = 32'h7fff_ffff;
  localparam logic [33:0] RealNegMag = 34'h0_8000_0000;

endpackage

/* rtl/core/affine_int8_quantizer_unit.sv */
// ---------------------------------------------------------------------------
// affine_int8_quantizer_unit
// per-tensor int8 affine quantize / dequantize / fake-quantize, six stages
// ---------------------------------------------------------------------------
//   channel  dir  handshake            payload
//   in_      in   in_tvalid/tready     tdata real_in, code_in; tuser op
//   out_     out  out_tvalid/tready    tdata code_out, real_out; tuser clipped
//   cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one request per cycle sustained while the output is not stalled; a request
// passes stages a to f in order, which hold the two multipliers (32x32 inv_scale,
// 9x32 scale), each followed by its own rounding stage
// rst_n is synchronous; it clears the stage valid bits and the config registers
// a stall at the output freezes every stage together, nothing is dropped
// cfg_ready is always high; the user must change registers only while the unit is idle, the unit does not enforce it
`include "assert_macros.svh"

module affine_int8_quantizer_unit (
  input  logic        clk,
  input  logic        rst_n,
  // request
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [31:0] real_in, [40:32] code_in, zero pad
  input  logic [1:0]  in_tuser,   // [1:0] op
  // result
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [8:0] code_out, [40:9] real_out, zero pad
  output logic [0:0]  out_tuser,  // [0] clipped
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // configuration registers
  logic        mode_sym_r;
  logic [31:0] scale_r;
  logic [31:0] inv_scale_r;
  logic [7:0]  zero_pt_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_sym_r  <= 1'b0;
      scale_r     <= affq_pkg::ScaleReset;
      inv_scale_r <= affq_pkg::InvScaleReset;
      zero_pt_r   <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (affq_pkg::cfg_idx_t'(cfg_index))
        affq_pkg::CFG_MODE_SYM:  mode_sym_r  <= cfg_data[0];
        affq_pkg::CFG_SCALE:     scale_r     <= cfg_data;
        affq_pkg::CFG_INV_SCALE: inv_scale_r <= cfg_data;
        affq_pkg::CFG_ZERO_PT:   zero_pt_r   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // pipeline control: all stages move together when the output can move
  logic [affq_pkg::StageCount-1:0] vld_r;
  logic [affq_pkg::StageCount-1:0] vld_nxt;
  logic                            adv;

  assign adv       = !vld_r[affq_pkg::StageCount-1] || out_tready;
  assign in_tready = adv;
  assign vld_nxt   = {vld_r[affq_pkg::StageCount-2:0], in_tvalid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  // stage a: unpack, magnitude of real_in
  logic [31:0] x_in;
  logic [1:0]  a_op_r,   a_op_nxt;
  logic        a_neg_r,  a_neg_nxt;
  logic [31:0] a_mag_r,  a_mag_nxt;
  logic [8:0]  a_code_r, a_code_nxt;

  always_comb begin
    x_in       = in_tdata[31:0];
    a_op_nxt   = in_tuser;
    a_neg_nxt  = x_in[31];
    // most negative input keeps its pattern, which is the right magnitude
    a_mag_nxt  = x_in[31] ? (~x_in + 32'd1) : x_in;
    a_code_nxt = in_tdata[40:32];
  end

  // stage b: |x| * inv_scale, exact Q32.32
  logic [1:0]  b_op_r;
  logic        b_neg_r;
  logic [63:0] b_prod_r, b_prod_nxt;
  logic [8:0]  b_code_r;

  assign b_prod_nxt = {32'd0, a_mag_r} * {32'd0, inv_scale_r};

  // stage c: round half even, sign, zero point, clamp
  logic [1:0]  c_op_r;
  logic [8:0]  c_code_r, c_code_nxt;   // quantized code
  logic        c_clip_r, c_clip_nxt;
  logic [8:0]  c_dqc_r,  c_dqc_nxt;    // code fed to dequantization
  logic        q_inc;
  logic [32:0] q_rm;
  logic signed [34:0] q_sr;
  logic signed [34:0] q_lo;
  logic signed [34:0] q_hi;

  always_comb begin
    q_inc = b_prod_r[31] && ((|b_prod_r[30:0]) || b_prod_r[32]);
    q_rm  = {1'b0, b_prod_r[63:32]} + {32'd0, q_inc};
    q_sr  = b_neg_r ? -$signed({2'b00, q_rm}) : $signed({2'b00, q_rm});
    if (mode_sym_r) begin
      q_lo = affq_pkg::SymLo;
      q_hi = affq_pkg::SymHi;
    end else begin
      q_sr = q_sr + $signed({27'd0, zero_pt_r});
      q_lo = affq_pkg::AsymLo;
      q_hi = affq_pkg::AsymHi;
    end
    c_clip_nxt = 1'b0;
    c_code_nxt = q_sr[8:0];
    if (q_sr < q_lo) begin
      c_code_nxt = q_lo[8:0];
      c_clip_nxt = 1'b1;
    end
    if (q_sr > q_hi) begin
      c_code_nxt = q_hi[8:0];
      c_clip_nxt = 1'b1;
    end
    // plain dequantize takes code_in over its full signed range
    c_dqc_nxt = (b_op_r == affq_pkg::OP_DEQUANT) ? b_code_r : c_code_nxt;
  end

  // stage d: diff = code - zero point, sign and magnitude
  logic [1:0]  d_op_r;
  logic [8:0]  d_code_r;
  logic        d_clip_r;
  logic        d_neg_r, d_neg_nxt;
  logic [8:0]  d_mag_r, d_mag_nxt;
  logic [9:0]  dq_diff;
  logic [9:0]  dq_neg;

  always_comb begin
    dq_diff   = {c_dqc_r[8], c_dqc_r} - (mode_sym_r ? 10'd0 : {2'b00, zero_pt_r});
    dq_neg    = ~dq_diff + 10'd1;
    d_neg_nxt = dq_diff[9];
    d_mag_nxt = dq_diff[9] ? dq_neg[8:0] : dq_diff[8:0];
  end

  // stage e: |diff| * scale, exact Q.24
  logic [1:0]  e_op_r;
  logic [8:0]  e_code_r;
  logic        e_clip_r;
  logic        e_neg_r;
  logic [40:0] e_prod_r, e_prod_nxt;

  assign e_prod_nxt = {32'd0, d_mag_r} * {9'd0, scale_r};

  // stage f: round to Q16.16, saturate, apply sign, mask by op
  logic        r_inc;
  logic [33:0] r_mag;
  logic [31:0] r_val;
  logic [31:0] r_neg;
  logic [8:0]  f_code_nxt;
  logic [31:0] f_real_nxt;
  logic        f_clip_nxt;
  logic [8:0]  f_code_r;
  logic [31:0] f_real_r;
  logic        f_clip_r;

  always_comb begin
    r_inc = e_prod_r[7] && ((|e_prod_r[6:0]) || e_prod_r[8]);
    r_mag = {1'b0, e_prod_r[40:8]} + {33'd0, r_inc};
    r_neg = '0;
    if (e_neg_r) begin
      // negative side may reach -2^31
      if (r_mag > affq_pkg::RealNegMag) begin
        r_neg = affq_pkg::RealNegMag[31:0];
      end else begin
        r_neg = r_mag[31:0];
      end
      r_val = 32'd0 - r_neg;
    end else if (r_mag > {2'b00, affq_pkg::RealPosMax}) begin
      r_val = affq_pkg::RealPosMax;
    end else begin
      r_val = r_mag[31:0];
    end
    case (affq_pkg::op_t'(e_op_r))
      affq_pkg::OP_QUANT: begin
        f_code_nxt = e_code_r;
        f_real_nxt = 32'd0;
        f_clip_nxt = e_clip_r;
      end
      affq_pkg::OP_DEQUANT: begin
        f_code_nxt = affq_pkg::CodeZero;
        f_real_nxt = r_val;
        f_clip_nxt = 1'b0;
      end
      affq_pkg::OP_FAKE: begin
        f_code_nxt = e_code_r;
        f_real_nxt = r_val;
        f_clip_nxt = e_clip_r;
      end
      default: begin
        // unused op code gives an all-zero result
        f_code_nxt = affq_pkg::CodeZero;
        f_real_nxt = 32'd0;
        f_clip_nxt = 1'b0;
      end
    endcase
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (adv) begin
      a_op_r   <= a_op_nxt;
      a_neg_r  <= a_neg_nxt;
      a_mag_r  <= a_mag_nxt;
      a_code_r <= a_code_nxt;

      b_op_r   <= a_op_r;
      b_neg_r  <= a_neg_r;
      b_prod_r <= b_prod_nxt;
      b_code_r <= a_code_r;

      c_op_r   <= b_op_r;
      c_code_r <= c_code_nxt;
      c_clip_r <= c_clip_nxt;
      c_dqc_r  <= c_dqc_nxt;

      d_op_r   <= c_op_r;
      d_code_r <= c_code_r;
      d_clip_r <= c_clip_r;
      d_neg_r  <= d_neg_nxt;
      d_mag_r  <= d_mag_nxt;

      e_op_r   <= d_op_r;
      e_code_r <= d_code_r;
      e_clip_r <= d_clip_r;
      e_neg_r  <= d_neg_r;
      e_prod_r <= e_prod_nxt;

      f_code_r <= f_code_nxt;
      f_real_r <= f_real_nxt;
      f_clip_r <= f_clip_nxt;
    end
  end

  assign out_tvalid = vld_r[affq_pkg::StageCount-1];
  assign out_tdata  = {7'd0, f_real_r, f_code_r};
  assign out_tuser  = f_clip_r;

  // a frozen pipeline keeps its occupancy
  `AQ_ASSERT_NXT(a_hold_on_stall, !adv, $stable(vld_r))
  // a request in the last working stage reaches the output when moving
  `AQ_ASSERT_NXT(a_last_stage_moves, adv && vld_r[affq_pkg::StageCount-2], out_tvalid)
  // a clipped code always sits on one of the range limits
  `AQ_ASSERT_NOW(a_clip_at_limit, out_tvalid && out_tuser[0],
    (out_tdata[8:0] == affq_pkg::CodeZero) || (out_tdata[8:0] == affq_pkg::CodeU8Max) ||
    (out_tdata[8:0] == affq_pkg::CodeS8Max) || (out_tdata[8:0] == affq_pkg::CodeS8Min))

endmodule

/* dv/affq_scoreboard_pkg.sv */
// ---------------------------------------------------------------------------
// affq_scoreboard_pkg
// expected-result tracking for the int8 affine quantizer testbench
// ---------------------------------------------------------------------------
package affq_scoreboard_pkg;

  import affq_pkg::*;

  typedef struct packed {
    logic [8:0]  code;
    logic [31:0] value;
    logic        clip;
  } quant_result_t;

  // magnitude rounded half to even, fb fraction bits dropped
  function automatic longint rne_shift(longint mag, int fb);
    longint ip, fr, half;
    ip   = mag >> fb;
    fr   = mag & ((longint'(1) << fb) - 1);
    half = longint'(1) << (fb - 1);
    if (fr > half || (fr == half && ip[0])) ip++;
    return ip;
  endfunction

  class quant_scoreboard;
    bit            sym_mode;
    longint        scale_q24;
    longint        inv_q16;
    longint        zero_code;
    quant_result_t awaited[$];
    int unsigned   fail_count;

    function new();
      sym_mode   = 1'b0;
      scale_q24  = longint'(ScaleReset);
      inv_q16    = longint'(InvScaleReset);
      zero_code  = 0;
      fail_count = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [31:0] v);
      case (idx)
        CFG_MODE_SYM:  sym_mode  = v[0];
        CFG_SCALE:     scale_q24 = longint'(v);
        CFG_INV_SCALE: inv_q16   = longint'(v);
        CFG_ZERO_PT:   zero_code = longint'(v[7:0]);
        default: ;
      endcase
    endfunction

    // Q16.16 value to clamped code, exact product then rounding
    function longint quantize_value(logic [31:0] x, output logic clip);
      longint xv, mag, r, lo, hi;
      xv  = x[31] ? longint'(x) - (longint'(1) << 32) : longint'(x);
      mag = (xv < 0) ? -xv : xv;
      r   = rne_shift(mag * inv_q16, 32);
      if (xv < 0) r = -r;
      if (sym_mode) begin
        lo = -127;
        hi = 127;
      end else begin
        r  = r + zero_code;
        lo = 0;
        hi = 255;
      end
      clip = 1'b0;
      if (r < lo) begin
        r    = lo;
        clip = 1'b1;
      end
      if (r > hi) begin
        r    = hi;
        clip = 1'b1;
      end
      return r;
    endfunction

    // signed code to saturated Q16.16
    function logic [31:0] dequantize_code(longint code);
      longint d, dm, m, t;
      d  = sym_mode ? code : code - zero_code;
      dm = (d < 0) ? -d : d;
      m  = rne_shift(dm * scale_q24, 8);
      if (d < 0) begin
        if (m > 64'h8000_0000) m = 64'h8000_0000;
        t = -m;
        return t[31:0];
      end
      if (m > 64'h7fff_ffff) m = 64'h7fff_ffff;
      return m[31:0];
    endfunction

    function void note_request(logic [1:0] op, logic [31:0] x, logic [8:0] c);
      quant_result_t e;
      longint        q, cv;
      logic          clip;
      e = '0;
      if (op == OP_QUANT || op == OP_FAKE) begin
        q      = quantize_value(x, clip);
        e.code = q[8:0];
        e.clip = clip;
        if (op == OP_FAKE) e.value = dequantize_code(q);
      end else if (op == OP_DEQUANT) begin
        cv      = c[8] ? longint'(c) - 512 : longint'(c);
        e.value = dequantize_code(cv);
      end
      // append at the tail of the expected queue
      awaited = {awaited, e};
    endfunction

    function void check_result(logic [8:0] code, logic [31:0] value, logic clip);
      quant_result_t e;
      if (awaited.size() == 0) begin
        $error("result with no request pending: code_out %0h real_out %0h", code, value);
        fail_count++;
        return;
      end
      e = awaited.pop_front();
      if (code !== e.code) begin
        $error("code_out mismatch: expected %0h actual %0h", e.code, code);
        fail_count++;
      end
      if (value !== e.value) begin
        $error("real_out mismatch: expected %0h actual %0h", e.value, value);
        fail_count++;
      end
      if (clip !== e.clip) begin
        $error("clipped mismatch: expected %0b actual %0b", e.clip, clip);
        fail_count++;
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

endpackage

/* dv/testbench.sv */
// ---------------------------------------------------------------------------
// testbench
// drives quantize, dequantize and fake-quantize requests through the unit
// under a series of register settings, with random gaps and stalls on both
// streams, and checks every result field against a local fixed-point model
// ---------------------------------------------------------------------------
module testbench;

  import affq_pkg::*;
  import affq_scoreboard_pkg::*;

  localparam int          ClkHalf      = 4;
  localparam int          ResetCycles  = 6;
  localparam int          PhaseCount   = 12;
  localparam int          RandPerPhase = 165;
  localparam int          RandTotal    = PhaseCount * RandPerPhase;
  localparam int          HoldCycles   = 40;
  localparam logic [1:0]  OpUnused     = 2'd3;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index  = '0;
  logic [31:0] cfg_data   = '0;

  // idle rates in percent, set by the stimulus thread
  int sender_idle_pct = 0;
  int recv_idle_pct   = 0;
  // bumped to ask the receiver for one long hold-off
  int hold_token      = 0;

  quant_scoreboard board;

  affine_int8_quantizer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #ClkHalf clk = ~clk;

  // result side: accepted results go straight to the checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      board.check_result(out_tdata[8:0], out_tdata[40:9], out_tuser[0]);
    end
  end

  // receiver back-pressure, plus the long hold-off that fills the pipeline
  initial begin
    int hold_seen;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        out_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // one request; random idle cycles first, then hold until accepted
  task automatic send_request(logic [1:0] op, logic [31:0] x, logic [8:0] c);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, c, x};
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    // noted here rather than in a monitor so the drain check cannot race it
    board.note_request(op, x, c);
  endtask

  // sender pause: nothing offered until every result has come back
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  // leaves cfg_valid high so back-to-back writes need no second assignment
  task automatic write_reg(cfg_idx_t idx, logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, v);
  endtask

  task automatic apply_settings(logic sym, logic [31:0] sc, logic [31:0] inv, logic [7:0] zp);
    write_reg(CFG_MODE_SYM, {31'd0, sym});
    write_reg(CFG_SCALE, sc);
    write_reg(CFG_INV_SCALE, inv);
    write_reg(CFG_ZERO_PT, {24'd0, zp});
    cfg_valid <= 1'b0;
  endtask

  // per-phase register settings: extremes first, then tie-prone, then random
  task automatic settings_for_phase(int ph);
    logic [31:0] sc;
    longint      inv;
    case (ph)
      1: apply_settings(1'b1, 32'h0000_0000, 32'hffff_ffff, 8'd255);
      2: apply_settings(1'b0, 32'hffff_ffff, 32'h0000_0000, 8'd255);
      3: apply_settings(1'b1, 32'hffff_ffff, 32'h0001_0000, 8'd0);
      4: apply_settings(1'b0, 32'h0000_0000, 32'hffff_ffff, 8'd0);
      // inv_scale of 3.0 makes half-way products common
      5: apply_settings(1'b1, 32'h0055_5555, 32'h0003_0000, 8'd0);
      6: apply_settings(1'b0, 32'h0055_5555, 32'h0003_0000, 8'd128);
      7: apply_settings(1'($urandom_range(1)), $urandom, $urandom, 8'($urandom_range(255)));
      default: begin
        // step between 1/256 and 4.0 with a matching reciprocal
        sc  = $urandom_range(32'h0400_0000, 32'h0001_0000);
        inv = (longint'(1) << 40) / longint'(sc);
        apply_settings(1'($urandom_range(1)), sc, inv[31:0], 8'($urandom_range(255)));
      end
    endcase
  endtask

  task automatic send_random_request();
    logic [1:0]  op;
    logic [31:0] x;
    logic [31:0] m32;
    logic [8:0]  c;
    longint      lim;
    if ($urandom_range(99) < 3) op = OpUnused;
    else op = 2'($urandom_range(2));
    c = 9'($urandom_range(511));
    case ($urandom_range(7))
      0: x = $urandom;
      1: begin
        case ($urandom_range(3))
          0: x = 32'h7fff_ffff;
          1: x = 32'h8000_0000;
          2: x = 32'h0000_0000;
          default: x = 32'hffff_ffff;
        endcase
      end
      default: begin
        // keep most values near the code range so rounding is exercised
        if (board.inv_q16 == 0) lim = 64'h7fff_ffff;
        else lim = (longint'(300) << 32) / board.inv_q16;
        if (lim > 64'h7fff_ffff) lim = 64'h7fff_ffff;
        m32 = $urandom_range(lim[31:0]);
        x   = $urandom_range(1) ? -m32 : m32;
        if ($urandom_range(3) == 0) x[15:0] = 16'h8000;
      end
    endcase
    send_request(op, x, c);
  endtask

  // directed requests under the reset settings: asymmetric, unit step, zero point 0
  task automatic send_directed();
    send_request(OP_QUANT, 32'h0000_0000, 9'h000);
    // half-way cases round to the even code
    send_request(OP_QUANT, 32'h0000_8000, 9'h000);
    send_request(OP_QUANT, 32'h0001_8000, 9'h000);
    send_request(OP_QUANT, 32'h0002_8000, 9'h000);
    send_request(OP_QUANT, 32'h00fe_8000, 9'h000);
    // 255.5 rounds to 256 and clamps
    send_request(OP_QUANT, 32'h00ff_8000, 9'h000);
    send_request(OP_QUANT, 32'hffff_8000, 9'h000);
    // -1.5 rounds to -2 and clamps to 0
    send_request(OP_QUANT, 32'hfffe_8000, 9'h000);
    send_request(OP_QUANT, 32'h7fff_ffff, 9'h1ff);
    send_request(OP_QUANT, 32'h8000_0000, 9'h100);
    // dequantize over the full 9-bit code range, unclamped
    send_request(OP_DEQUANT, 32'hffff_ffff, 9'h0ff);
    send_request(OP_DEQUANT, 32'h0000_0000, 9'h100);
    send_request(OP_DEQUANT, 32'h8000_0000, 9'h1ff);
    send_request(OP_DEQUANT, 32'h7fff_ffff, 9'h181);
    send_request(OP_DEQUANT, 32'h0000_0000, 9'h000);
    send_request(OP_FAKE, 32'h0064_4000, 9'h000);
    send_request(OP_FAKE, 32'h8000_0000, 9'h0ff);
    send_request(OP_FAKE, 32'h7fff_ffff, 9'h1ff);
    // unused op gives an all-zero result
    send_request(OpUnused, 32'hffff_ffff, 9'h1ff);
    send_request(OpUnused, 32'h0000_0000, 9'h000);
  endtask

  // stimulus thread
  initial begin
    int sent;
    sent  = 0;
    board = new();
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int ph = 0; ph < PhaseCount; ph++) begin
      // registers change only with the pipeline empty
      if (ph > 0) begin
        wait_for_results();
        settings_for_phase(ph);
      end else begin
        sender_idle_pct = 18;
        recv_idle_pct   = 52;
        send_directed();
      end
      for (int k = 0; k < RandPerPhase; k++) begin
        // idle schedule: sender light / receiver heavy, then swapped, then none
        if (sent < RandTotal / 3) begin
          sender_idle_pct = 18;
          recv_idle_pct   = 52;
        end else if (sent < 2 * RandTotal / 3) begin
          sender_idle_pct = 52;
          recv_idle_pct   = 18;
        end else begin
          sender_idle_pct = 0;
          recv_idle_pct   = 0;
        end
        // long receiver hold-off while requests keep coming
        if ((ph == 4 || ph == 10) && k == 60) hold_token++;
        // sender pause mid-phase until the pipeline has drained
        if (ph == 9 && k == 80) wait_for_results();
        send_random_request();
        sent++;
      end
    end

    wait_for_results();
    repeat (StageCount + 4) @(posedge clk);
    if (board.fail_count == 0 && board.pending() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // watchdog, well beyond the slowest legal run
  initial begin
    #(2 * ClkHalf * 400000);
    $display("testbench failed");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/affq_pkg.sv
rtl/core/affine_int8_quantizer_unit.sv
dv/affq_scoreboard_pkg.sv
dv/testbench.sv
